[rtl/mpq_pkg.sv]
// Package: sizes, codes and controller/datapath interface types of the priority queue.
package mpq_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PRIO_W  = 16;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = PRIO_W + DATA_W;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_SCAN_END,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic insert;
        logic scan;
        logic shift_init;
        logic shift;
        logic dec_count;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic count_full;
        logic count_empty;
        logic scan_last;
        logic shift_done;
        logic out_free;
    } t_stat;

endpackage

[rtl/mpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mpq_ctrl.sv]
// Controller: sequences insert, scan, shift and result hand-off.
module mpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_mode,
    input  mpq_pkg::t_stat i_stat,
    output mpq_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    mpq_pkg::t_state r_state;
    mpq_pkg::t_state n_state;
    logic            w_accept;

    assign w_accept = i_in_valid && (r_state == mpq_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mpq_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == mpq_pkg::MODE_INSERT && !i_stat.count_full) begin
                        n_state = mpq_pkg::S_INSERT;
                    end else if (i_mode == mpq_pkg::MODE_REMOVE && !i_stat.count_empty) begin
                        n_state = mpq_pkg::S_SCAN;
                    end else begin
                        n_state = mpq_pkg::S_FINISH;
                    end
                end
            end
            mpq_pkg::S_INSERT:   n_state = mpq_pkg::S_FINISH;
            mpq_pkg::S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = mpq_pkg::S_SCAN_END;
                end
            end
            mpq_pkg::S_SCAN_END: n_state = mpq_pkg::S_SHIFT;
            mpq_pkg::S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = mpq_pkg::S_FINISH;
                end
            end
            mpq_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = mpq_pkg::S_IDLE;
                end
            end
            default:             n_state = mpq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            mpq_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = w_accept;
            end
            mpq_pkg::S_INSERT:   o_cmd.insert = 1'b1;
            mpq_pkg::S_SCAN:     o_cmd.scan = 1'b1;
            mpq_pkg::S_SCAN_END: o_cmd.shift_init = 1'b1;
            mpq_pkg::S_SHIFT: begin
                o_cmd.shift     = 1'b1;
                o_cmd.dec_count = i_stat.shift_done;
            end
            mpq_pkg::S_FINISH:   o_cmd.out_load = i_stat.out_free;
            default:             o_busy = 1'b1;
        endcase
    end

endmodule

[rtl/mpq_dp.sv]
// Datapath: entry store, fill count, max scan, gap-closing shift and result register.
module mpq_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mpq_pkg::t_cmd                      i_cmd,
    output mpq_pkg::t_stat                     o_stat,
    input  logic                               i_mode,
    input  logic signed [mpq_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic signed [mpq_pkg::DATA_W-1:0]  i_payload,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic signed [mpq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic signed [mpq_pkg::DATA_W-1:0]  o_out_payload
);

    localparam int AW = mpq_pkg::ADDR_W;
    localparam int CW = mpq_pkg::CNT_W;
    localparam int PW = mpq_pkg::PRIO_W;
    localparam int DW = mpq_pkg::DATA_W;
    localparam int EW = mpq_pkg::ENTRY_W;

    logic [CW-1:0]          r_count;
    logic                   r_mode;
    logic [PW-1:0]          r_prio;
    logic [DW-1:0]          r_payload;
    mpq_pkg::t_status       r_status;
    logic [CW-1:0]          r_addr;
    logic                   r_rd_vld;
    logic                   r_rd_scan;
    logic [AW-1:0]          r_rd_tag;
    logic [AW-1:0]          r_best_idx;
    logic signed [PW-1:0]   r_best_prio;
    logic [DW-1:0]          r_best_payload;
    logic                   r_out_valid;
    mpq_pkg::t_status       r_out_status;
    logic [PW-1:0]          r_out_prio;
    logic [DW-1:0]          r_out_payload;

    logic [AW-1:0]          n_best_idx;
    logic signed [PW-1:0]   n_best_prio;
    logic [DW-1:0]          n_best_payload;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [EW-1:0]          w_wdata;
    logic [EW-1:0]          w_rdata;
    logic signed [PW-1:0]   w_rd_prio;
    logic                   w_take;
    logic                   w_shift_issue;
    logic                   w_out_free;
    logic                   w_full;
    logic                   w_empty;

    mpq_ram #(
        .WIDTH (EW),
        .DEPTH (mpq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_full        = (r_count == CW'(mpq_pkg::DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_shift_issue = i_cmd.shift && (r_addr < r_count);

    // insert appends at the fill count; shift moves entry tag down to tag-1
    always_comb begin
        if (i_cmd.insert) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = {r_prio, r_payload};
        end else begin
            w_we    = r_rd_vld && !r_rd_scan;
            w_waddr = r_rd_tag - AW'(1);
            w_wdata = w_rdata;
        end
    end

    // running maximum; strict compare keeps the earliest among ties
    assign w_rd_prio = w_rdata[EW-1:DW];
    assign w_take    = (r_rd_tag == '0) || (w_rd_prio > r_best_prio);

    always_comb begin
        n_best_idx     = r_best_idx;
        n_best_prio    = r_best_prio;
        n_best_payload = r_best_payload;
        if (r_rd_vld && r_rd_scan && w_take) begin
            n_best_idx     = r_rd_tag;
            n_best_prio    = w_rd_prio;
            n_best_payload = w_rdata[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_scan   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
            r_rd_vld  <= i_cmd.scan || w_shift_issue;
            r_rd_scan <= i_cmd.scan;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_prio    <= i_priority_req;
            r_payload <= i_payload;
            r_addr    <= '0;
            if (i_mode == mpq_pkg::MODE_REMOVE) begin
                r_status <= w_empty ? mpq_pkg::ST_EMPTY : mpq_pkg::ST_OK;
            end else begin
                r_status <= w_full ? mpq_pkg::ST_FULL : mpq_pkg::ST_OK;
            end
        end else if (i_cmd.scan || w_shift_issue) begin
            r_addr <= r_addr + CW'(1);
        end else if (i_cmd.shift_init) begin
            r_addr <= CW'(n_best_idx) + CW'(1);
        end
        r_rd_tag       <= r_addr[AW-1:0];
        r_best_idx     <= n_best_idx;
        r_best_prio    <= n_best_prio;
        r_best_payload <= n_best_payload;
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            if (r_status == mpq_pkg::ST_OK && r_mode == mpq_pkg::MODE_REMOVE) begin
                r_out_prio    <= r_best_prio;
                r_out_payload <= r_best_payload;
            end else begin
                r_out_prio    <= '0;
                r_out_payload <= '0;
            end
        end
    end

    assign o_stat.count_full  = w_full;
    assign o_stat.count_empty = w_empty;
    assign o_stat.scan_last   = (r_addr == r_count - CW'(1));
    assign o_stat.shift_done  = (r_addr >= r_count);
    assign o_stat.out_free    = w_out_free;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_priority = r_out_prio;
    assign o_out_payload  = r_out_payload;

endmodule

[rtl/max_priority_queue_top.sv]
// Top level of the bounded max priority queue: controller, datapath and checks.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  request | in        | i_in_valid / o_in_stall   | i_mode, i_priority_req, i_payload
//  result  | out       | o_out_valid / i_out_stall | o_status, o_out_priority, o_out_payload
//
//  Insert writes the request at the fill count; a full or empty request only reports its status.
//  Remove makes one store read a cycle, first over all stored entries to find the maximum,
//  then from the winner's slot upwards for the shift that closes the gap; then the result.
//  Reset (i_rst_n low, synchronous) empties the queue; store contents are left as they are.
//  o_in_stall is high whenever an item is in progress; a result held by i_out_stall
//  keeps the block in its finish step, so at most one result is ever outstanding.
module max_priority_queue_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic signed [mpq_pkg::PRIO_W-1:0] i_priority_req,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_payload,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic signed [mpq_pkg::PRIO_W-1:0] o_out_priority,
    output logic signed [mpq_pkg::DATA_W-1:0] o_out_payload
);

    mpq_pkg::t_cmd  w_cmd;
    mpq_pkg::t_stat w_stat;
    logic           w_busy;

    // sequencer: one state per phase of an operation
    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // store, scan comparator, shift and result register
    mpq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_mode         (i_mode),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_payload  (o_out_payload)
    );

    assign o_in_stall = w_busy;

`ifndef SYNTH
    // a write at the fill count never happens on a full queue
    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.insert |-> !w_stat.count_full)
        else $error("insert issued on a full queue");

    // an entry is only taken out of a non-empty queue
    a_dec_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.dec_count |-> !w_stat.count_empty)
        else $error("fill count decremented below zero");

    // reports other than a successful remove carry zero fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != mpq_pkg::ST_OK) |->
            (o_out_priority == '0 && o_out_payload == '0))
        else $error("non-zero fields on a full or empty report");

    // the result register is only loaded when it is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten while still held");
`endif

endmodule
